// ----- rtl/sorted_priority_queue_macros.svh -----
// Assertion helpers used by the checks in the queue module.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted priority queue check failed");

// Next-cycle implication, disabled while reset is held.
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue check failed");

`endif

// ----- rtl/spq_pkg.sv -----
package spq_pkg;

    localparam int VAL_W = 32;
    localparam int PRI_W = 8;

    // Command codes carried on the input tuser.
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Operation broadcast to every cell in the chain.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [VAL_W-1:0] value;
        logic [PRI_W-1:0] pri;
    } t_op;

endpackage

// ----- rtl/sorted_priority_queue.sv -----
// Sorted priority queue built from a chain of shift cells, front entry in cell 0.
// A result is registered when its input is taken and shown in the cycle after the transfer.
// One command per cycle while the output side is not stalled; cells compare and shift at once.
// Reset (synchronous, active low) empties the queue and the output register;
// cell contents are left as they are and are never read while unoccupied.
module sorted_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side. tdata: value [31:0], priority_req [39:32]. tuser: cmd [0].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [0:0]  s_tuser,
    // Master side. tdata: popped_value [31:0], head_value [63:32].
    // tuser: popped_valid [0], empty_res [1], full_res [2], rejected [3].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic [3:0]  m_tuser
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // Occupancy count; cell k is occupied when k is below it.
    logic [CW-1:0] r_count, n_count;

    // Output register that parts the two sides of the block.
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_popped, r_out_head;
    logic             r_out_pvalid, r_out_empty, r_out_full, r_out_rej;

    logic             w_accept, w_full, w_empty, w_rej;
    logic [VAL_W-1:0] w_in_value;
    logic [PRI_W-1:0] w_in_pri;
    t_op              w_op;

    logic [VAL_W-1:0] w_value [CAPACITY];
    logic [PRI_W-1:0] w_pri   [CAPACITY];
    logic             w_keep  [CAPACITY];
    logic [VAL_W-1:0] w_next_value [CAPACITY];

    // A new command is taken whenever the output register is free or draining,
    // and never while reset is held.
    assign s_tready = i_rst_n && (!r_out_valid || m_tready);
    assign w_accept = s_tvalid && s_tready;

    assign w_in_value = s_tdata[VAL_W-1:0];
    assign w_in_pri   = s_tdata[VAL_W+PRI_W-1:VAL_W];
    assign w_full     = (r_count == CAP_CNT);
    assign w_empty    = (r_count == '0);

    // Enqueue into a full queue is dropped; dequeue from an empty queue does nothing.
    assign w_op.ins   = w_accept && (s_tuser[0] == CMD_ENQ) && !w_full;
    assign w_op.del   = w_accept && (s_tuser[0] == CMD_DEQ) && !w_empty;
    assign w_op.value = w_in_value;
    assign w_op.pri   = w_in_pri;
    assign w_rej      = w_accept && (s_tuser[0] == CMD_ENQ) && w_full;

    // The chain: each cell looks at its left neighbor for inserts and its right
    // neighbor for removals. Cell 0 sees the new entry itself as its left neighbor,
    // and the last cell feeds itself on removal since its old content is discarded.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        localparam logic [CW-1:0] K_IDX = CW'(k);
        logic [VAL_W-1:0] w_lv, w_rv;
        logic [PRI_W-1:0] w_lp, w_rp;
        logic             w_lk;

        if (k == 0) begin : g_first
            assign w_lv = w_in_value;
            assign w_lp = w_in_pri;
            assign w_lk = 1'b0;
        end else begin : g_mid
            assign w_lv = w_value[k-1];
            assign w_lp = w_pri[k-1];
            assign w_lk = w_keep[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign w_rv = w_value[k];
            assign w_rp = w_pri[k];
        end else begin : g_inner
            assign w_rv = w_value[k+1];
            assign w_rp = w_pri[k+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (w_op),
            .i_occ        (r_count > K_IDX),
            .i_left_value (w_lv),
            .i_left_pri   (w_lp),
            .i_left_keep  (w_lk),
            .i_right_value(w_rv),
            .i_right_pri  (w_rp),
            .o_value      (w_value[k]),
            .o_pri        (w_pri[k]),
            .o_keep       (w_keep[k]),
            .o_next_value (w_next_value[k])
        );
    end

    always_comb begin
        n_count = r_count;
        priority if (w_op.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_op.del) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: the head after this step is the next value of cell 0.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_popped <= w_op.del ? w_value[0] : '0;
            r_out_pvalid <= w_op.del;
            r_out_head   <= (n_count != '0) ? w_next_value[0] : '1;
            r_out_empty  <= (n_count == '0);
            r_out_full   <= (n_count == CAP_CNT);
            r_out_rej    <= w_rej;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {r_out_head, r_out_popped};
    assign m_tuser  = {r_out_rej, r_out_full, r_out_empty, r_out_pvalid};

    `include "sorted_priority_queue_macros.svh"

    `SPQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CAP_CNT)
    `SPQ_ASSERT_IMP(a_rej_full, i_clk, i_rst_n, r_out_valid && r_out_rej, r_out_full)
    `SPQ_ASSERT_IMP(a_empty_head, i_clk, i_rst_n, r_out_valid && r_out_empty, r_out_head == '1)
    `SPQ_ASSERT_NXT(a_pop_count, i_clk, i_rst_n, w_op.del, r_count == $past(r_count) - 1'b1)

endmodule

// ----- rtl/spq_cell.sv -----
module spq_cell (
    input  logic                      i_clk,
    input  spq_pkg::t_op              i_op,
    input  logic                      i_occ,
    input  logic [spq_pkg::VAL_W-1:0] i_left_value,
    input  logic [spq_pkg::PRI_W-1:0] i_left_pri,
    input  logic                      i_left_keep,
    input  logic [spq_pkg::VAL_W-1:0] i_right_value,
    input  logic [spq_pkg::PRI_W-1:0] i_right_pri,
    output logic [spq_pkg::VAL_W-1:0] o_value,
    output logic [spq_pkg::PRI_W-1:0] o_pri,
    output logic                      o_keep,
    output logic [spq_pkg::VAL_W-1:0] o_next_value
);
    import spq_pkg::*;

    logic [VAL_W-1:0] r_value, n_value;
    logic [PRI_W-1:0] r_pri, n_pri;

    // An occupied entry whose priority is at least the new one stays in place.
    assign o_keep = i_occ && (r_pri >= i_op.pri);

    always_comb begin
        n_value = r_value;
        n_pri   = r_pri;
        priority if (i_op.ins) begin
            if (!o_keep) begin
                // The first cell that moves takes the new entry, the rest shift right.
                n_value = i_left_keep ? i_op.value : i_left_value;
                n_pri   = i_left_keep ? i_op.pri   : i_left_pri;
            end
        end else if (i_op.del) begin
            n_value = i_right_value;
            n_pri   = i_right_pri;
        end else begin
            n_value = r_value;
            n_pri   = r_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_pri   <= n_pri;
    end

    assign o_value      = r_value;
    assign o_pri        = r_pri;
    assign o_next_value = n_value;

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1600;
    // The limit is set above the slowest legal run, in which every item meets the longest
    // idle gap, the longest stall and the latency of the block.
    localparam int CYCLE_LIMIT  = 600000;
    // The block registers a result at its input transfer and shows it in the cycle after.
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    // One command as it travels on the slave side.
    typedef struct packed {
        logic             cmd;
        logic [VAL_W-1:0] value;
        logic [PRI_W-1:0] prio;
    } t_queue_cmd;

    // One result, in the field order used for comparison.
    typedef struct packed {
        logic [VAL_W-1:0] popped_value;
        logic             popped_valid;
        logic [VAL_W-1:0] head_value;
        logic             empty_res;
        logic             full_res;
        logic             rejected;
    } t_queue_outcome;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // tdata: value [31:0], priority_req [39:32].
    logic [39:0] s_tdata  = '0;
    // tuser: cmd [0].
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // tdata: popped_value [31:0], head_value [63:32].
    logic [63:0] m_tdata;
    // tuser: popped_valid [0], empty_res [1], full_res [2], rejected [3].
    logic [3:0]  m_tuser;

    sorted_priority_queue #(
        .CAPACITY(QUEUE_DEPTH)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow copy of the sorted store, front entry at index 0.
    logic [VAL_W-1:0] shadow_value [QUEUE_DEPTH];
    logic [PRI_W-1:0] shadow_prio  [QUEUE_DEPTH];
    int               shadow_count = 0;

    t_queue_cmd     cmd_backlog[$];
    t_queue_outcome outcome_queue[$];
    t_queue_cmd     cmd_on_bus;

    int unsigned tx_idle = 0;
    int unsigned tx_quiet = 0;
    int unsigned rx_idle = 0;
    int unsigned rx_quiet = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count = 0;

    // Applies one command to the shadow store and returns the result it must produce.
    // A new entry goes behind every stored entry of greater or equal priority, which
    // keeps equal priorities in arrival order.
    function automatic t_queue_outcome predict_outcome(t_queue_cmd c);
        t_queue_outcome o;
        int             pos;
        o = '0;
        if (c.cmd == CMD_ENQ) begin
            if (shadow_count >= QUEUE_DEPTH) begin
                o.rejected = 1'b1;
            end else begin
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] >= c.prio)
                    pos++;
                for (int k = shadow_count; k > pos; k--) begin
                    shadow_value[k] = shadow_value[k-1];
                    shadow_prio[k]  = shadow_prio[k-1];
                end
                shadow_value[pos] = c.value;
                shadow_prio[pos]  = c.prio;
                shadow_count++;
            end
        end else if (shadow_count > 0) begin
            o.popped_value = shadow_value[0];
            o.popped_valid = 1'b1;
            for (int k = 1; k < shadow_count; k++) begin
                shadow_value[k-1] = shadow_value[k];
                shadow_prio[k-1]  = shadow_prio[k];
            end
            shadow_count--;
        end
        o.head_value = (shadow_count > 0) ? shadow_value[0] : '1;
        o.empty_res  = (shadow_count == 0);
        o.full_res   = (shadow_count >= QUEUE_DEPTH);
        return o;
    endfunction

    // Mostly back-to-back, some short pauses, and now and then a long one.
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void check_result(t_queue_outcome got);
        t_queue_outcome want;
        if (outcome_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("Unexpected result: tdata %h tuser %b", m_tdata, m_tuser);
        end else begin
            want = outcome_queue.pop_front();
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("Mismatch at result %0d (expected/actual):", results_checked);
                    $display("  popped_value %h/%h popped_valid %b/%b head_value %h/%h",
                             want.popped_value, got.popped_value,
                             want.popped_valid, got.popped_valid,
                             want.head_value, got.head_value);
                    $display("  empty %b/%b full %b/%b rejected %b/%b",
                             want.empty_res, got.empty_res,
                             want.full_res, got.full_res,
                             want.rejected, got.rejected);
                end
            end
        end
    endfunction

    task automatic add_cmd(input logic op, input logic [VAL_W-1:0] word,
                           input logic [PRI_W-1:0] prio_pick);
        t_queue_cmd c;
        c.cmd   = op;
        c.value = word;
        c.prio  = prio_pick;
        cmd_backlog.push_back(c);
    endtask

    // Driver: presents the backlog on the slave side. The expectation for a command
    // is computed at the edge where its transfer happens, so the shadow store follows
    // the block in acceptance order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                outcome_queue.push_back(predict_outcome(cmd_on_bus));
                if (tx_quiet > 0)
                    tx_quiet--;
                else if ($urandom_range(0, 99) < 4)
                    tx_quiet = $urandom_range(30, 150);
                tx_idle = (tx_quiet > 0) ? 0 : idle_length();
            end
            // A command that was offered but not taken stays on the bus unchanged.
            if (!s_tvalid || s_tready) begin
                if (tx_idle > 0) begin
                    tx_idle--;
                    s_tvalid <= 1'b0;
                end else if (cmd_backlog.size() > 0) begin
                    cmd_on_bus = cmd_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cmd_on_bus.prio, cmd_on_bus.value};
                    s_tuser  <= cmd_on_bus.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes results on the master side with random back-pressure and
    // checks each one against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result({m_tdata[31:0], m_tuser[0], m_tdata[63:32],
                              m_tuser[1], m_tuser[2], m_tuser[3]});
                results_checked++;
                if (rx_quiet > 0)
                    rx_quiet--;
                else if ($urandom_range(0, 99) < 4)
                    rx_quiet = $urandom_range(30, 150);
                rx_idle = (rx_quiet > 0) ? 0 : idle_length();
            end else if (rx_idle == 0 && rx_quiet == 0 && !m_tvalid
                         && $urandom_range(0, 99) < 5) begin
                // Drop ready now and then while nothing is offered as well.
                rx_idle = $urandom_range(1, 6);
            end
            if (rx_idle > 0) begin
                rx_idle--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned      n;
        int unsigned      phase_left;
        int unsigned      enq_weight;
        int unsigned      prio_mode;
        int unsigned      items_total;
        logic [PRI_W-1:0] prio_base;
        logic [VAL_W-1:0] word;
        logic [PRI_W-1:0] prio_pick;
        logic             op;

        // Directed part. A dequeue on the empty queue comes first.
        add_cmd(CMD_DEQ, '1, '1);
        // Extreme values and priorities; two entries of top priority test arrival order.
        add_cmd(CMD_ENQ, 32'h7FFF_FFFF, 8'd0);
        add_cmd(CMD_ENQ, 32'h8000_0000, 8'd255);
        add_cmd(CMD_ENQ, 32'hFFFF_FFFF, 8'd255);
        add_cmd(CMD_ENQ, 32'h0000_0000, 8'd0);
        // Fill to capacity with a mix of repeated priorities.
        for (int k = 0; k < QUEUE_DEPTH - 4; k++)
            add_cmd(CMD_ENQ, 32'h0000_0100 + k, 8'(k % 4) * 8'd60);
        // Enqueue into the full queue is rejected, whatever its priority.
        add_cmd(CMD_ENQ, 32'h1234_5678, 8'd255);
        add_cmd(CMD_ENQ, 32'hA5A5_5A5A, 8'd0);
        // A few dequeues with garbage in the ignored fields.
        add_cmd(CMD_DEQ, 32'hFFFF_FFFF, 8'hFF);
        add_cmd(CMD_DEQ, 32'h0000_0000, 8'h00);
        add_cmd(CMD_DEQ, 32'h5555_5555, 8'hAA);
        add_cmd(CMD_DEQ, 32'hAAAA_AAAA, 8'h55);

        // Random part in phases: a fill-heavy phase pushes the queue into the full
        // state, a drain-heavy phase empties it, and a balanced one stirs the middle.
        // Narrow priority bands produce long runs of equal priorities.
        n = 0;
        while (n < RANDOM_ITEMS) begin
            phase_left = $urandom_range(15, 60);
            case ($urandom_range(0, 2))
                0:       enq_weight = 85;
                1:       enq_weight = 50;
                default: enq_weight = 15;
            endcase
            prio_mode = $urandom_range(0, 2);
            prio_base = 8'($urandom_range(0, 252));
            while (phase_left > 0 && n < RANDOM_ITEMS) begin
                op = ($urandom_range(0, 99) < enq_weight) ? CMD_ENQ : CMD_DEQ;
                word = $urandom;
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       word = 32'h8000_0000;
                        1:       word = 32'h7FFF_FFFF;
                        2:       word = '0;
                        default: word = '1;
                    endcase
                end
                case (prio_mode)
                    0:       prio_pick = 8'($urandom_range(0, 255));
                    1:       prio_pick = prio_base + 8'($urandom_range(0, 3));
                    default: prio_pick = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
                endcase
                add_cmd(op, word, prio_pick);
                phase_left--;
                n++;
            end
        end
        items_total = cmd_backlog.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (results_checked < items_total)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && outcome_queue.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
